[design/cfr_pkg.sv]
// Shared types and codes for the clock frame replacement engine.
`timescale 1ns / 1ps

package cfr_pkg;

    // Input action codes
    localparam logic [1:0] ACT_INSTALL = 2'd0;
    localparam logic [1:0] ACT_TOUCH   = 2'd1;
    localparam logic [1:0] ACT_EVICT   = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_VICTIM = 2'd1;
    localparam logic [1:0] STATUS_NONE   = 2'd2;

    localparam int SLOT_W = 6;
    localparam int AGE_W  = 2;

    // Command kind after classification in the front end
    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_INSTALL,
        KIND_TOUCH,
        KIND_EVICT
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

    // Per-slot state as held in the frame table
    typedef struct packed {
        logic             valid;
        logic             ref_bit;
        logic [AGE_W-1:0] age;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INST,
        ST_TOUCH,
        ST_SWEEP
    } state_t;

    // Back end status toward the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

[design/cfr_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module cfr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/cfr_front.sv]
// Front end: accepts input transfers, classifies them and queues commands.
`timescale 1ns / 1ps

module cfr_front #(
    parameter int FRAMES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_action,
    input  logic [5:0]            in_slot,
    input  cfr_pkg::back_status_t back_status,
    output logic                  q_valid,
    output cfr_pkg::cmd_t         q_cmd,
    input  logic                  q_pop
);

    cfr_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    cfr_pkg::cmd_t cls_cmd;
    logic          in_range;
    logic          push;

    assign in_range = 32'(in_slot) < FRAMES;

    always_comb
    begin
        cls_cmd.slot = in_slot;
        case (in_action)
            cfr_pkg::ACT_INSTALL:
                cls_cmd.kind = in_range ? cfr_pkg::KIND_INSTALL : cfr_pkg::KIND_NOP;
            cfr_pkg::ACT_TOUCH:
                cls_cmd.kind = in_range ? cfr_pkg::KIND_TOUCH : cfr_pkg::KIND_NOP;
            cfr_pkg::ACT_EVICT:
                cls_cmd.kind = cfr_pkg::KIND_EVICT;
            default:
                cls_cmd.kind = cfr_pkg::KIND_NOP;
        endcase
    end

    assign in_ready = !back_status.clearing && (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

[design/cfr_back.sv]
// Back end: frame table, clock hand sweep and result register.
`timescale 1ns / 1ps

module cfr_back #(
    parameter int FRAMES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            limit,
    input  logic                  q_valid,
    input  cfr_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    output cfr_pkg::back_status_t back_status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_status,
    output logic [5:0]            out_victim
);

    localparam int AW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    cfr_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   hand_reg, hand_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg;
    logic [5:0]      out_victim_reg;

    logic            res_valid;
    logic [1:0]      res_status;
    logic [5:0]      res_victim;
    logic [AW-1:0]   hand_nxt;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    cfr_pkg::entry_t wdata;
    cfr_pkg::entry_t rdata;
    logic [cfr_pkg::ENTRY_W-1:0] rdata_raw;

    cfr_ram #(
        .WIDTH(cfr_pkg::ENTRY_W),
        .DEPTH(FRAMES)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata_raw)
    );

    assign rdata = rdata_raw;
    assign hand_nxt = (hand_reg == AW'(FRAMES - 1)) ? '0 : hand_reg + AW'(1);

    always_comb
    begin
        state_next = state_reg;
        hand_next  = hand_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        waddr      = slot_reg;
        wdata      = '0;
        raddr      = hand_reg;
        res_valid  = 1'b0;
        res_status = cfr_pkg::STATUS_DONE;
        res_victim = '0;

        case (state_reg)
            cfr_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                if (clr_reg == AW'(FRAMES - 1))
                begin
                    state_next = cfr_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            cfr_pkg::ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        cfr_pkg::KIND_INSTALL:
                        begin
                            raddr      = AW'(q_cmd.slot);
                            slot_next  = AW'(q_cmd.slot);
                            state_next = cfr_pkg::ST_INST;
                        end
                        cfr_pkg::KIND_TOUCH:
                        begin
                            raddr      = AW'(q_cmd.slot);
                            slot_next  = AW'(q_cmd.slot);
                            state_next = cfr_pkg::ST_TOUCH;
                        end
                        cfr_pkg::KIND_EVICT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res_status = cfr_pkg::STATUS_NONE;
                            end
                            else
                            begin
                                raddr      = hand_reg;
                                state_next = cfr_pkg::ST_SWEEP;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            cfr_pkg::ST_INST:
            begin
                we            = 1'b1;
                wdata.valid   = 1'b1;
                if (!rdata.valid)
                begin
                    count_next = count_reg + CW'(1);
                end
                res_valid  = 1'b1;
                state_next = cfr_pkg::ST_IDLE;
            end
            cfr_pkg::ST_TOUCH:
            begin
                we            = rdata.valid;
                wdata         = rdata;
                wdata.ref_bit = 1'b1;
                res_valid     = 1'b1;
                state_next    = cfr_pkg::ST_IDLE;
            end
            cfr_pkg::ST_SWEEP:
            begin
                // One slot per cycle: write back the current slot, read the next.
                waddr     = hand_reg;
                raddr     = hand_nxt;
                hand_next = hand_nxt;
                if (rdata.valid)
                begin
                    we = 1'b1;
                    if (rdata.ref_bit)
                    begin
                        wdata.valid = 1'b1;
                    end
                    else if (rdata.age >= limit)
                    begin
                        count_next = count_reg - CW'(1);
                        res_valid  = 1'b1;
                        res_status = cfr_pkg::STATUS_VICTIM;
                        res_victim = 6'(hand_reg);
                        state_next = cfr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        wdata.valid = 1'b1;
                        wdata.age   = rdata.age + cfr_pkg::AGE_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = cfr_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfr_pkg::ST_CLEAR;
            hand_reg      <= '0;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (res_valid)
        begin
            out_status_reg <= res_status;
            out_victim_reg <= res_victim;
        end
    end

    assign back_status.clearing = (state_reg == cfr_pkg::ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_victim = out_victim_reg;

endmodule

[design/clock_frame_replacement.sv]
// Top level of the clock (second-chance) frame replacement engine.
//
// Input stream s_*: one command per transfer (install, touch or evict).
// Output stream m_*: exactly one result per command, in command order.
// Config channel cfg_*: writes age_limit (0 acts as 1); write only while idle.
//
// Commands go through a two-entry queue into the table engine, so input
// transfers keep being taken while a result waits in the output register.
// Install and touch read the table in the engine, then write it.
// Evict sweeps the hand over the slots, one slot a cycle, until it finds a
// victim; an evict with no occupied slot returns status none without a sweep.
// The engine starts a command only when the output register is empty, so
// a stalled m_tready holds the engine; the queue then fills and s_tready
// drops. After reset the frame table is cleared one slot a cycle, with
// s_tready low; the config channel stays open.
`timescale 1ns / 1ps

module clock_frame_replacement #(
    parameter int FRAMES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [1:0] action, [7:2] slot
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] status, [7:2] victim_slot
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    logic [1:0]            age_limit_reg, age_limit_next;
    logic [1:0]            limit;
    logic                  q_valid;
    logic                  q_pop;
    cfr_pkg::cmd_t         q_cmd;
    cfr_pkg::back_status_t back_status;
    logic [1:0]            out_status;
    logic [5:0]            out_victim;

    assign cfg_ready      = 1'b1;
    assign age_limit_next = cfg_valid ? cfg_data : age_limit_reg;
    assign limit          = (age_limit_reg == 2'd0) ? 2'd1 : age_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= 2'd1;
        end
        else
        begin
            age_limit_reg <= age_limit_next;
        end
    end

    cfr_front #(
        .FRAMES(FRAMES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tdata[1:0]),
        .in_slot    (s_tdata[7:2]),
        .back_status(back_status),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    cfr_back #(
        .FRAMES(FRAMES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .back_status(back_status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_victim (out_victim)
    );

    assign m_tdata = {out_victim, out_status};

endmodule
